// ===== rtl/ssd_pkg.sv =====
// Shared types and constants for the stable set difference unit.
package ssd_pkg;
    localparam int MaxItems = 32;
    localparam int ValueW = 32;
    localparam int PosW = 5;
    localparam int CountW = 6;

    localparam logic [1:0] REQ_B = 2'd0;
    localparam logic [1:0] REQ_A = 2'd1;
    localparam logic [1:0] REQ_END = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [ValueW-1:0] value;
    } t_in;

    typedef struct packed {
        logic [ValueW-1:0] value_res;
        logic [PosW-1:0] position;
        logic [CountW-1:0] count;
        logic error;
        logic last;
    } t_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;      // capture the input transaction
        logic write_b;      // append captured value to B store
        logic start_scan;   // clear scan index and hit flag
        logic scan_step;    // compare one entry of each store
        logic keep;         // append captured value to kept store
        logic a_done;       // count one A element
        logic set_ovf;      // mark overflow
        logic emit_load;    // load output register from read port
        logic emit_next;    // advance emit index
        logic clear_job;    // clear counts and overflow
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] req_type;
        logic b_full;
        logic a_full;
        logic kept_full;
        logic scan_done;
        logic hit;
        logic ovf;
        logic kept_empty;
        logic emit_last;
    } t_stat;

    function automatic logic fp_equal(input logic [31:0] x, input logic [31:0] y);
        logic [30:0] mx;
        logic [30:0] my;
        mx = x[30:0];
        my = y[30:0];
        if (mx > 31'h7F800000 || my > 31'h7F800000) begin
            return 1'b0;
        end
        if (mx == '0 && my == '0) begin
            return 1'b1;
        end
        return x == y;
    endfunction
endpackage

// ===== rtl/ssd_if.sv =====
// Valid/ready channel interface carrying a payload.
interface ssd_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/stable_set_difference_unit.sv =====
// Top level of the stable set difference unit.
// Usage:
//   Input channel carries req_type and value: B elements (0) are stored,
//   A elements (1) are scanned against the kept and B stores, end of job
//   (2) emits the answer. Request type 3 is dropped.
//   Output channel carries value_res, position, count, error and last.
// Sequencing:
//   A element: one entry of each store read per cycle through the stores'
//   shared scan address. End of job: after the decode and read states,
//   results are loaded and sent one at a time; the next result is loaded
//   only after the receiver takes the current one.
//   The unit handles one transaction at a time.
// Reset: counts and overflow clear; store contents stay undefined and are
//   never read beyond the fill counts.
// Stall: a result holds on the output until taken; no input is accepted
//   until the last result of a job is delivered.
module stable_set_difference_unit #(
    parameter int MAX_ITEMS = ssd_pkg::MaxItems
) (
    input logic i_clk,
    input logic i_rst_n,
    ssd_if.sink i_in,
    ssd_if.source o_out
);
    import ssd_pkg::*;
    t_cmd w_cmd;
    t_stat w_stat;

    ssd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    ssd_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(i_in.payload), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_out(o_out.payload)
    );
endmodule

// ===== rtl/ssd_datapath.sv =====
// Datapath: B store, kept store, scan compare and output register.
module ssd_datapath #(
    parameter int MAX_ITEMS = ssd_pkg::MaxItems
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  ssd_pkg::t_in i_in,
    input  ssd_pkg::t_cmd i_cmd,
    output ssd_pkg::t_stat o_stat,
    output ssd_pkg::t_out o_out
);
    import ssd_pkg::*;
    localparam int IdxW = $clog2(MAX_ITEMS);
    localparam int CntW = $clog2(MAX_ITEMS + 1);

    logic [ValueW-1:0] r_b_mem [MAX_ITEMS];
    logic [ValueW-1:0] r_k_mem [MAX_ITEMS];
    logic [PosW-1:0] r_p_mem [MAX_ITEMS];

    logic [1:0] r_req;
    logic [ValueW-1:0] r_val;
    logic [CntW-1:0] r_b_cnt, r_k_cnt, r_a_cnt, r_idx;
    logic r_ovf, r_hit;
    logic [ValueW-1:0] r_b_rd, r_k_rd;
    logic [PosW-1:0] r_p_rd;
    logic r_rd_vld;   // read data of r_idx-1 valid
    logic [CntW-1:0] r_rd_idx;
    t_out r_out;

    wire [IdxW-1:0] w_ra = r_idx[IdxW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_b) begin
            r_b_mem[r_b_cnt[IdxW-1:0]] <= r_val;
        end
        if (i_cmd.keep) begin
            r_k_mem[r_k_cnt[IdxW-1:0]] <= r_val;
            r_p_mem[r_k_cnt[IdxW-1:0]] <= PosW'(r_a_cnt);
        end
        r_b_rd <= r_b_mem[w_ra];
        r_k_rd <= r_k_mem[w_ra];
        r_p_rd <= r_p_mem[w_ra];
        if (i_cmd.load_in) begin
            r_req <= i_in.req_type;
            r_val <= i_in.value;
        end
    end

    logic w_k_hit, w_b_hit;
    always_comb begin
        w_k_hit = r_rd_vld && (r_rd_idx < r_k_cnt) && fp_equal(r_k_rd, r_val);
        w_b_hit = r_rd_vld && (r_rd_idx < r_b_cnt) && fp_equal(r_b_rd, r_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_cnt <= '0;
            r_k_cnt <= '0;
            r_a_cnt <= '0;
            r_ovf <= 1'b0;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_rd_vld <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_rd_vld <= 1'b0;
            if (i_cmd.start_scan) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (r_idx < CntW'(MAX_ITEMS)) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_rd_vld <= r_idx < CntW'(MAX_ITEMS);
                r_rd_idx <= r_idx;
                if (w_k_hit || w_b_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.emit_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.write_b) begin
                r_b_cnt <= r_b_cnt + 1'b1;
            end
            if (i_cmd.keep) begin
                r_k_cnt <= r_k_cnt + 1'b1;
            end
            if (i_cmd.a_done) begin
                r_a_cnt <= r_a_cnt + 1'b1;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.clear_job) begin
                r_b_cnt <= '0;
                r_k_cnt <= '0;
                r_a_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // Output register: error, empty, or kept entry from the read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            if (r_ovf) begin
                r_out <= '{value_res: '0, position: '0, count: '0, error: 1'b1, last: 1'b1};
            end else if (r_k_cnt == '0) begin
                r_out <= '{value_res: '0, position: '0, count: '0, error: 1'b0, last: 1'b1};
            end else begin
                r_out.value_res <= r_k_rd;
                r_out.position <= r_p_rd;
                r_out.count <= CountW'(r_k_cnt);
                r_out.error <= 1'b0;
                r_out.last <= (r_idx == r_k_cnt);
            end
        end
    end

    always_comb begin
        o_stat.req_type = r_req;
        o_stat.b_full = r_b_cnt >= CntW'(MAX_ITEMS);
        o_stat.a_full = r_a_cnt >= CntW'(MAX_ITEMS);
        o_stat.kept_full = r_k_cnt >= CntW'(MAX_ITEMS);
        o_stat.scan_done = !r_rd_vld && (r_idx == CntW'(MAX_ITEMS));
        o_stat.hit = r_hit;
        o_stat.ovf = r_ovf;
        o_stat.kept_empty = r_k_cnt == '0;
        o_stat.emit_last = r_idx >= r_k_cnt;
        o_out = r_out;
    end
endmodule

// ===== rtl/ssd_ctrl.sv =====
// Controller state machine sequencing store, scan and emit.
module ssd_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  ssd_pkg::t_stat i_stat,
    output ssd_pkg::t_cmd o_cmd
);
    import ssd_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_SEND = 3'd5;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                o_cmd.start_scan = 1'b1;
                unique case (i_stat.req_type)
                    REQ_B: begin
                        if (i_stat.b_full) begin
                            o_cmd.set_ovf = 1'b1;
                        end else begin
                            o_cmd.write_b = 1'b1;
                        end
                    end
                    REQ_A: begin
                        if (i_stat.a_full) begin
                            o_cmd.set_ovf = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    REQ_END: n_state = S_RD;
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.scan_step = 1'b0;
                    o_cmd.a_done = 1'b1;
                    o_cmd.keep = !i_stat.hit && !i_stat.kept_full;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                // read port now addresses the emit index
                o_cmd.emit_next = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.emit_load = 1'b1;
                n_state = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.ovf || i_stat.kept_empty || i_stat.emit_last) begin
                        o_cmd.clear_job = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
